/* rtl/x86su_pkg.sv */
// ----------------------------------------------------------------------------
// x86su_pkg
// Types and constants shared by the segment unit modules.
// ----------------------------------------------------------------------------
package x86su_pkg;

    typedef enum logic [1:0] {
        OP_TRANSLATE  = 2'd0,
        OP_LOAD_DATA  = 2'd1,
        OP_LOAD_CODE  = 2'd2,
        OP_WRITE_MODE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LIMIT   = 2'd1,
        ST_MEMORY  = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] limit;
        logic [7:0]  access;
        logic        big;
        logic        ok;
    } t_desc;

    localparam logic [2:0]  CS_INDEX       = 3'd1;
    localparam logic [15:0] SEL_INDEX_MASK = 16'hFFF8;
    localparam logic [15:0] CS_RESET_SEL   = 16'hF000;
    localparam logic [31:0] CS_RESET_BASE  = 32'h000F_0000;
    localparam logic [31:0] LIMIT_1M       = 32'h000F_FFFF;
    localparam logic [31:0] LIMIT_64K      = 32'h0000_FFFF;
    localparam int          OUT_BITS       = 24;

    localparam int ACC_PRESENT = 7;
    localparam int ACC_SYSTEM  = 4;
    localparam int ACC_CODE    = 3;
    localparam int HI_GRAN     = 23;
    localparam int HI_BIG      = 22;

endpackage

/* rtl/x86su_decode.sv */
// ----------------------------------------------------------------------------
// x86su_decode
// Decodes a descriptor pair and checks the selector against the table limit.
// ----------------------------------------------------------------------------
module x86su_decode (
    input  logic [15:0]     i_sel,
    input  logic [31:0]     i_desc_lo,
    input  logic [31:0]     i_desc_hi,
    input  logic [15:0]     i_gdt_limit,
    output x86su_pkg::t_desc o_desc
);

    logic [15:0] sel_idx;
    logic        sel_ok;
    logic [31:0] raw_limit;

    assign sel_idx   = i_sel & x86su_pkg::SEL_INDEX_MASK;
    assign sel_ok    = (sel_idx != 16'd0) &&
                       (({1'b0, sel_idx} + 17'd7) <= {1'b0, i_gdt_limit});
    assign raw_limit = {12'd0, i_desc_hi[19:16], i_desc_lo[15:0]};

    always_comb begin
        o_desc.base   = {i_desc_hi[31:24], i_desc_hi[7:0], i_desc_lo[31:16]};
        o_desc.limit  = i_desc_hi[x86su_pkg::HI_GRAN] ?
                        {raw_limit[19:0], 12'hFFF} : raw_limit;
        o_desc.access = i_desc_hi[15:8];
        o_desc.big    = i_desc_hi[x86su_pkg::HI_BIG];
        o_desc.ok     = sel_ok && i_desc_hi[8 + x86su_pkg::ACC_PRESENT] &&
                        i_desc_hi[8 + x86su_pkg::ACC_SYSTEM];
    end

endmodule

/* rtl/x86su_exec.sv */
// ----------------------------------------------------------------------------
// x86su_exec
// Segment register file, mode flags and the single-pass operation logic,
// with the result register.
// ----------------------------------------------------------------------------
module x86su_exec #(
    parameter int ADDRESS_BITS  = 24,
    parameter int SEGMENT_COUNT = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  x86su_pkg::t_opcode      i_op,
    input  logic [2:0]              i_seg,
    input  logic [15:0]             i_sel,
    input  x86su_pkg::t_desc        i_desc,
    input  logic [31:0]             i_off,
    input  logic                    i_mode,
    output logic                    o_done,
    output logic [23:0]             o_addr,
    output x86su_pkg::t_status      o_status,
    output logic                    o_d32
);

    localparam logic [31:0] MEM_MASK = 32'((64'd1 << ADDRESS_BITS) - 64'd1);
    localparam int          IDX_W    = $clog2(SEGMENT_COUNT);
    localparam logic [IDX_W-1:0] CS_IDX = IDX_W'(x86su_pkg::CS_INDEX);

    logic [15:0] r_sel    [SEGMENT_COUNT];
    logic [31:0] r_base   [SEGMENT_COUNT];
    logic [31:0] r_limit  [SEGMENT_COUNT];
    logic [7:0]  r_access [SEGMENT_COUNT];
    logic [15:0] n_sel    [SEGMENT_COUNT];
    logic [31:0] n_base   [SEGMENT_COUNT];
    logic [31:0] n_limit  [SEGMENT_COUNT];
    logic [7:0]  n_access [SEGMENT_COUNT];
    logic        r_prot, n_prot;
    logic        r_d32, n_d32;

    logic                 r_done;
    logic [23:0]          r_addr, n_addr;
    x86su_pkg::t_status   r_status, n_status;

    logic                 seg_ok;
    logic [IDX_W-1:0]     idx;
    logic [31:0]          real_sum;
    logic [32:0]          prot_sum;
    logic [31:0]          addr32;

    assign seg_ok   = {29'd0, i_seg} < SEGMENT_COUNT;
    assign idx      = i_seg[IDX_W-1:0];
    assign real_sum = {12'd0, r_sel[idx], 4'd0} + i_off;
    assign prot_sum = {1'b0, r_base[idx]} + {1'b0, i_off};

    always_comb begin
        n_sel    = r_sel;
        n_base   = r_base;
        n_limit  = r_limit;
        n_access = r_access;
        n_prot   = r_prot;
        n_d32    = r_d32;
        addr32   = 32'd0;
        n_status = x86su_pkg::ST_OK;
        case (i_op)
            x86su_pkg::OP_TRANSLATE: begin
                if (!seg_ok) begin
                    n_status = x86su_pkg::ST_INVALID;
                end else if (!r_prot) begin
                    addr32 = real_sum & MEM_MASK;
                end else if (i_off > r_limit[idx]) begin
                    n_status = x86su_pkg::ST_LIMIT;
                end else if ((prot_sum >> ADDRESS_BITS) != 33'd0) begin
                    n_status = x86su_pkg::ST_MEMORY;
                end else begin
                    addr32 = prot_sum[31:0];
                end
            end
            x86su_pkg::OP_LOAD_DATA: begin
                if (!seg_ok) begin
                    n_status = x86su_pkg::ST_INVALID;
                end else if (!r_prot) begin
                    n_sel[idx]    = i_sel;
                    n_base[idx]   = {12'd0, i_sel, 4'd0};
                    n_limit[idx]  = x86su_pkg::LIMIT_64K;
                    n_access[idx] = 8'd0;
                end else if (i_seg == x86su_pkg::CS_INDEX || !i_desc.ok ||
                             i_desc.access[x86su_pkg::ACC_CODE]) begin
                    n_status = x86su_pkg::ST_INVALID;
                end else begin
                    n_sel[idx]    = i_sel;
                    n_base[idx]   = i_desc.base;
                    n_limit[idx]  = i_desc.limit;
                    n_access[idx] = i_desc.access;
                end
            end
            x86su_pkg::OP_LOAD_CODE: begin
                n_sel[CS_IDX] = i_sel;
                if (r_prot) begin
                    if (!i_desc.ok || !i_desc.access[x86su_pkg::ACC_CODE]) begin
                        n_status = x86su_pkg::ST_INVALID;
                    end else begin
                        n_base[CS_IDX]   = i_desc.base;
                        n_limit[CS_IDX]  = i_desc.limit;
                        n_access[CS_IDX] = i_desc.access;
                        n_d32            = i_desc.big;
                    end
                end
            end
            default: begin
                n_prot = i_mode;
                if (i_mode) begin
                    n_base[CS_IDX]  = {12'd0, r_sel[CS_IDX], 4'd0};
                    n_limit[CS_IDX] = x86su_pkg::LIMIT_1M;
                end
            end
        endcase
        n_addr = addr32[x86su_pkg::OUT_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SEGMENT_COUNT; i++) begin
                r_sel[i]    <= (i == int'(CS_IDX)) ? x86su_pkg::CS_RESET_SEL : 16'd0;
                r_base[i]   <= (i == int'(CS_IDX)) ? x86su_pkg::CS_RESET_BASE : 32'd0;
                r_limit[i]  <= x86su_pkg::LIMIT_1M;
                r_access[i] <= 8'd0;
            end
            r_prot <= 1'b0;
            r_d32  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
            if (i_valid) begin
                r_sel    <= n_sel;
                r_base   <= n_base;
                r_limit  <= n_limit;
                r_access <= n_access;
                r_prot   <= n_prot;
                r_d32    <= n_d32;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_addr   <= n_addr;
            r_status <= n_status;
        end
    end

    assign o_done   = r_done;
    assign o_addr   = r_addr;
    assign o_status = r_status;
    assign o_d32    = r_d32;

    // A faulting transaction never reports an address.
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_status != x86su_pkg::ST_OK |-> r_addr == 24'd0)
        else $error("fault reported with a nonzero address");

    // Every accepted transaction gives its result in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> r_done)
        else $error("result strobe missing");

    // Real mode never raises a limit or memory fault.
    a_real_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !r_prot |=> r_status != x86su_pkg::ST_LIMIT &&
                               r_status != x86su_pkg::ST_MEMORY)
        else $error("limit or memory fault in real mode");

    // Flags only move with a transaction.
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |=> $stable(r_d32) && $stable(r_prot))
        else $error("mode flags changed while idle");

endmodule

/* rtl/x86_segment_unit_core.sv */
// ----------------------------------------------------------------------------
// x86_segment_unit_core
// Segment unit: real and protected mode address translation and segment
// register loads from supplied descriptor words.
//
//   Channel   Handshake                 Payload
//   command   i_start / o_busy          i_opcode, i_segment_index,
//                                       i_selector_value, i_descriptor_low,
//                                       i_descriptor_high, i_offset_value,
//                                       i_mode_bit
//   result    o_done (one-cycle strobe) o_linear_address, o_status_code,
//                                       o_code_is_32bit
//   config    i_cfg_valid / o_cfg_ready i_cfg_data (descriptor table limit)
//
// A transaction is registered at acceptance in the input registers, then
// decoded and executed, and its result is held in the result register;
// one transaction can be accepted every cycle and o_busy is never raised.
// The path is set by the base plus offset add and the limit compare in the
// execute stage. Synchronous reset restores the power-on segment state.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module x86_segment_unit_core #(
    parameter int ADDRESS_BITS  = 24,
    parameter int SEGMENT_COUNT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_segment_index,
    input  logic [15:0] i_selector_value,
    input  logic [31:0] i_descriptor_low,
    input  logic [31:0] i_descriptor_high,
    input  logic [31:0] i_offset_value,
    input  logic        i_mode_bit,
    output logic        o_done,
    output logic [23:0] o_linear_address,
    output logic [1:0]  o_status_code,
    output logic        o_code_is_32bit,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic                r_valid;
    x86su_pkg::t_opcode  r_op;
    logic [2:0]          r_seg;
    logic [15:0]         r_sel;
    logic [31:0]         r_desc_lo;
    logic [31:0]         r_desc_hi;
    logic [31:0]         r_off;
    logic                r_mode;
    logic [15:0]         r_gdt_limit;
    x86su_pkg::t_desc    desc;
    x86su_pkg::t_status  status;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_gdt_limit <= 16'd0;
        end else begin
            r_valid <= i_start && !o_busy;
            if (i_cfg_valid && o_cfg_ready) begin
                r_gdt_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_op      <= x86su_pkg::t_opcode'(i_opcode);
            r_seg     <= i_segment_index;
            r_sel     <= i_selector_value;
            r_desc_lo <= i_descriptor_low;
            r_desc_hi <= i_descriptor_high;
            r_off     <= i_offset_value;
            r_mode    <= i_mode_bit;
        end
    end

    x86su_decode u_decode (
        .i_sel       (r_sel),
        .i_desc_lo   (r_desc_lo),
        .i_desc_hi   (r_desc_hi),
        .i_gdt_limit (r_gdt_limit),
        .o_desc      (desc)
    );

    x86su_exec #(
        .ADDRESS_BITS  (ADDRESS_BITS),
        .SEGMENT_COUNT (SEGMENT_COUNT)
    ) u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_valid),
        .i_op     (r_op),
        .i_seg    (r_seg),
        .i_sel    (r_sel),
        .i_desc   (desc),
        .i_off    (r_off),
        .i_mode   (r_mode),
        .o_done   (o_done),
        .o_addr   (o_linear_address),
        .o_status (status),
        .o_d32    (o_code_is_32bit)
    );

    assign o_status_code = status;

endmodule
